@@ rtl/led_fbb_pkg.sv @@
// ----------------------------------------------------------------------------
// led_fbb_pkg
// Shared constants and types for the LED frame buffer with brightness.
// ----------------------------------------------------------------------------
package led_fbb_pkg;

    localparam int LED_COUNT = 25;
    localparam int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int IDX_W     = 6;
    localparam int FUNC_W    = 2;
    localparam int COLOR_W   = 8;

    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

    localparam logic [COLOR_W-1:0] BRIGHT_RESET = 8'd127;

    typedef struct packed {
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic              we;
        logic              clr;
        logic [ADDR_W-1:0] waddr;
    } t_store_ctl;

endpackage

@@ rtl/led_frame_buffer_brightness_unit.sv @@
// ----------------------------------------------------------------------------
// led_frame_buffer_brightness_unit
// LED frame buffer with global brightness; set, clear and flush requests.
//
//   channel   handshake                  payload
//   input     i_valid / o_ready          func, led_index, red/green/blue_in
//   output    o_valid / i_ready          green/red/blue_out, last_led
//   config    i_cfg_valid / o_cfg_ready  brightness
//
// Set: the shared multiplier scales red, green, blue in turn, then the pixel
// is written. Clear, ignored set and unused code finish in the idle state. Flush:
// each LED in turn from the output register, held while the output stalls.
// Reset clears the store valid bits at once; brightness resets to 127.
// ----------------------------------------------------------------------------
module led_frame_buffer_brightness_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [led_fbb_pkg::FUNC_W-1:0]  i_func,
    input  logic [led_fbb_pkg::IDX_W-1:0]   i_led_index,
    input  logic [led_fbb_pkg::COLOR_W-1:0] i_red_in,
    input  logic [led_fbb_pkg::COLOR_W-1:0] i_green_in,
    input  logic [led_fbb_pkg::COLOR_W-1:0] i_blue_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [led_fbb_pkg::COLOR_W-1:0] o_green_out,
    output logic [led_fbb_pkg::COLOR_W-1:0] o_red_out,
    output logic [led_fbb_pkg::COLOR_W-1:0] o_blue_out,
    output logic                            o_last_led,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [led_fbb_pkg::COLOR_W-1:0] i_cfg_data
);
    import led_fbb_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCALE = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam logic [1:0] STEP_RED   = 2'd0;
    localparam logic [1:0] STEP_GREEN = 2'd1;
    localparam logic [1:0] STEP_BLUE  = 2'd2;
    localparam logic [1:0] STEP_WRITE = 2'd3;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(LED_COUNT - 1);
    localparam logic [IDX_W:0]    IDX_LIMIT = (IDX_W + 1)'(LED_COUNT);

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_step;
    logic [ADDR_W-1:0]  r_addr;
    logic [COLOR_W-1:0] r_bright;
    logic [ADDR_W-1:0]  r_waddr;
    logic [COLOR_W-1:0] r_red_in, r_green_in, r_blue_in;
    logic [COLOR_W-1:0] r_red_s, r_green_s;

    logic               r_out_valid;
    t_pixel             r_out;
    logic               r_out_last;

    logic               w_accept;
    logic               w_in_range;
    logic               w_load;
    logic [COLOR_W-1:0] w_operand;
    logic [COLOR_W-1:0] w_quot;
    t_store_ctl         w_ctl;
    t_pixel             w_wdata;
    t_pixel             w_rdata;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_in_range  = ({1'b0, i_led_index} < IDX_LIMIT);
    assign w_load      = (r_state == ST_FLUSH) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= BRIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bright <= i_cfg_data;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_func == FUNC_SET && w_in_range) begin
                        n_state = ST_SCALE;
                    end else if (i_func == FUNC_FLUSH) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_SCALE: begin
                if (r_step == STEP_WRITE) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (w_load && r_addr == ADDR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_RED;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCALE) begin
                r_step <= r_step + 2'd1;
            end else begin
                r_step <= STEP_RED;
            end
            if (w_load) begin
                r_addr <= (r_addr == ADDR_LAST) ? '0 : r_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_waddr    <= i_led_index[ADDR_W-1:0];
            r_red_in   <= i_red_in;
            r_green_in <= i_green_in;
            r_blue_in  <= i_blue_in;
        end
        if (r_state == ST_SCALE && r_step == STEP_GREEN) begin
            r_red_s <= w_quot;
        end
        if (r_state == ST_SCALE && r_step == STEP_BLUE) begin
            r_green_s <= w_quot;
        end
    end

    always_comb begin
        case (r_step)
            STEP_RED:   w_operand = r_red_in;
            STEP_GREEN: w_operand = r_green_in;
            default:    w_operand = r_blue_in;
        endcase
    end

    led_fbb_scale u_scale (
        .i_clk    (i_clk),
        .i_value  (w_operand),
        .i_factor (r_bright),
        .o_quot   (w_quot)
    );

    assign w_ctl.we    = (r_state == ST_SCALE) && (r_step == STEP_WRITE);
    assign w_ctl.clr   = w_accept && (i_func == FUNC_CLEAR);
    assign w_ctl.waddr = r_waddr;
    assign w_wdata.green = r_green_s;
    assign w_wdata.red   = r_red_s;
    assign w_wdata.blue  = w_quot;

    led_fbb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out      <= w_rdata;
            r_out_last <= (r_addr == ADDR_LAST);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_green_out = r_out.green;
    assign o_red_out   = r_out.red;
    assign o_blue_out  = r_out.blue;
    assign o_last_led  = r_out_last;

`ifndef SYNTHESIS
    a_flush_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_FLUSH) |=> (r_state == ST_FLUSH))
        else $error("flush request did not start the frame walk");

    a_set_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_SET && w_in_range) |=> (r_state == ST_SCALE && !o_ready))
        else $error("in-range set did not start scaling");

    a_no_stray_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FLUSH && !(o_valid && !i_ready)) |=> !o_valid)
        else $error("result appeared outside a flush");
`endif

endmodule

@@ rtl/led_fbb_scale.sv @@
// ----------------------------------------------------------------------------
// led_fbb_scale
// Shared colour scaler: floor(v * factor / 255). Product registered,
// divide by 255 done as a reciprocal add on the registered product.
// ----------------------------------------------------------------------------
module led_fbb_scale (
    input  logic                          i_clk,
    input  logic [led_fbb_pkg::COLOR_W-1:0] i_value,
    input  logic [led_fbb_pkg::COLOR_W-1:0] i_factor,
    output logic [led_fbb_pkg::COLOR_W-1:0] o_quot
);
    import led_fbb_pkg::*;

    logic [2*COLOR_W-1:0] r_prod;
    logic [2*COLOR_W-1:0] n_prod;
    logic [2*COLOR_W-1:0] w_sum;

    assign n_prod = {{COLOR_W{1'b0}}, i_value} * {{COLOR_W{1'b0}}, i_factor};

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // exact for products below 65535
    assign w_sum  = r_prod + {{(2*COLOR_W-1){1'b0}}, 1'b1}
                  + {{COLOR_W{1'b0}}, r_prod[2*COLOR_W-1:COLOR_W]};
    assign o_quot = w_sum[2*COLOR_W-1:COLOR_W];

endmodule

@@ rtl/led_fbb_store.sv @@
// ----------------------------------------------------------------------------
// led_fbb_store
// Pixel store: one entry per LED with a valid bit each. Invalid entries
// read as zero, so reset and clear take effect at once.
// ----------------------------------------------------------------------------
module led_fbb_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  led_fbb_pkg::t_store_ctl        i_ctl,
    input  led_fbb_pkg::t_pixel            i_wdata,
    input  logic [led_fbb_pkg::ADDR_W-1:0] i_raddr,
    output led_fbb_pkg::t_pixel            o_rdata
);
    import led_fbb_pkg::*;

    logic [LED_COUNT-1:0] r_valid;
    t_pixel               r_mem [LED_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_ctl.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_valid[i_raddr] ? r_mem[i_raddr] : '0;

endmodule
